/* rtl/ttsr_pkg.sv */
// Shared types and constants for the tilt-to-stepper rate ramp block.
// Used by ttsr_mul, ttsr_div and tilt_to_stepper_rate_ramp_top; no dependencies.
package ttsr_pkg;

    localparam int TILT_W   = 17;
    localparam int CFG16_W  = 16;
    localparam int TICK_W   = 27;
    localparam int CMP_W    = 26;
    localparam int PROD_W   = 2 * CFG16_W;
    localparam int IDX_W    = 3;
    localparam int ITER_W   = 5;

    // Quotient bits produced for the request scaling and the period division
    localparam int REQ_ITERS  = CFG16_W;
    localparam int TICK_ITERS = TICK_W;

    // Configuration register indexes
    localparam logic [IDX_W-1:0] REG_DEAD_BAND = 3'd0;
    localparam logic [IDX_W-1:0] REG_FULL_TILT = 3'd1;
    localparam logic [IDX_W-1:0] REG_MIN_RATE  = 3'd2;
    localparam logic [IDX_W-1:0] REG_MAX_RATE  = 3'd3;
    localparam logic [IDX_W-1:0] REG_RAMP_STEP = 3'd4;
    localparam logic [IDX_W-1:0] REG_TICK_RATE = 3'd5;

    // Reset values of the configuration registers
    localparam logic [CFG16_W-1:0] RST_DEAD_BAND = 16'd1792;
    localparam logic [CFG16_W-1:0] RST_FULL_TILT = 16'd5632;
    localparam logic [CFG16_W-1:0] RST_MIN_RATE  = 16'd120;
    localparam logic [CFG16_W-1:0] RST_MAX_RATE  = 16'd1200;
    localparam logic [CFG16_W-1:0] RST_RAMP_STEP = 16'd20;
    localparam logic [TICK_W-1:0]  RST_TICK_RATE = 27'd1000000;

    // Request to the shared bit-serial divider
    typedef struct packed {
        logic                start;
        logic [CFG16_W-1:0]  rem_init;
        logic [TICK_W-1:0]   dividend;
        logic [CFG16_W-1:0]  divisor;
        logic [ITER_W-1:0]   iters;
    } div_req_t;

endpackage

/* rtl/ttsr_mul.sv */
// Bit-serial 16 x 16 unsigned shift-and-add multiplier, one multiplier bit per cycle.
// Depends on ttsr_pkg for widths.
module ttsr_mul (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [ttsr_pkg::CFG16_W-1:0]    a,
    input  logic [ttsr_pkg::CFG16_W-1:0]    b,
    output logic                            done,
    output logic [ttsr_pkg::PROD_W-1:0]     product
);

    localparam int CNT_W = $clog2(ttsr_pkg::CFG16_W);

    logic                           busy_reg, busy_next;
    logic                           done_reg, done_next;
    logic [CNT_W-1:0]               cnt_reg, cnt_next;
    logic [ttsr_pkg::PROD_W-1:0]    a_reg, a_next;
    logic [ttsr_pkg::CFG16_W-1:0]   b_reg, b_next;
    logic [ttsr_pkg::PROD_W-1:0]    acc_reg, acc_next;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(ttsr_pkg::CFG16_W - 1);
            a_next    = ttsr_pkg::PROD_W'(a);
            b_next    = b;
            acc_next  = '0;
        end
        else if (busy_reg)
        begin
            // add the shifted multiplicand where the current multiplier bit is set
            if (b_reg[0])
            begin
                acc_next = acc_reg + a_reg;
            end
            a_next   = {a_reg[ttsr_pkg::PROD_W-2:0], 1'b0};
            b_next   = {1'b0, b_reg[ttsr_pkg::CFG16_W-1:1]};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            a_reg    <= '0;
            b_reg    <= '0;
            acc_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            a_reg    <= a_next;
            b_reg    <= b_next;
            acc_reg  <= acc_next;
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

/* rtl/ttsr_div.sv */
// Bit-serial restoring divider, one quotient bit per cycle, shared by the
// request scaling and the timer period division. Depends on ttsr_pkg.
module ttsr_div (
    input  logic                            clk,
    input  logic                            rst_n,
    input  ttsr_pkg::div_req_t              req,
    output logic                            done,
    output logic [ttsr_pkg::TICK_W-1:0]     quotient
);

    logic                           busy_reg, busy_next;
    logic                           done_reg, done_next;
    logic [ttsr_pkg::ITER_W-1:0]    cnt_reg, cnt_next;
    logic [ttsr_pkg::CFG16_W-1:0]   rem_reg, rem_next;
    logic [ttsr_pkg::TICK_W-1:0]    num_reg, num_next;
    logic [ttsr_pkg::TICK_W-1:0]    q_reg, q_next;
    logic [ttsr_pkg::CFG16_W-1:0]   dvs_reg, dvs_next;
    logic [ttsr_pkg::CFG16_W:0]     rem_sh;
    logic [ttsr_pkg::CFG16_W:0]     rem_sub;
    logic                           fits;

    // Remainder stays below the divisor, so the shifted value needs one extra bit
    assign rem_sh  = {rem_reg, num_reg[ttsr_pkg::TICK_W-1]};
    assign fits    = rem_sh >= {1'b0, dvs_reg};
    assign rem_sub = rem_sh - {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        num_next  = num_reg;
        q_next    = q_reg;
        dvs_next  = dvs_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = req.iters;
            rem_next  = req.rem_init;
            num_next  = req.dividend;
            q_next    = '0;
            dvs_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? rem_sub[ttsr_pkg::CFG16_W-1:0] : rem_sh[ttsr_pkg::CFG16_W-1:0];
            q_next   = {q_reg[ttsr_pkg::TICK_W-2:0], fits};
            num_next = {num_reg[ttsr_pkg::TICK_W-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == ttsr_pkg::ITER_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            num_reg  <= '0;
            q_reg    <= '0;
            dvs_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            rem_reg  <= rem_next;
            num_reg  <= num_next;
            q_reg    <= q_next;
            dvs_reg  <= dvs_next;
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

/* rtl/tilt_to_stepper_rate_ramp_top.sv */
// Top level of the tilt-to-stepper rate ramp: control sequencer, settings and state.
// Depends on ttsr_pkg, ttsr_mul and ttsr_div.
//
// One tilt beat per control tick enters on in_valid/in_ready; one result beat
// leaves on out_valid/out_ready carrying the new step rate, timer reload,
// half-period compare value and the running/direction/loaded/started flags.
// Settings are written through wr_en/wr_index/wr_data, one register per cycle.
// Write them only while no tick is in flight; the block does not enforce this.
// The block handles one tick at a time. out_valid rises after S_UPDATE when
// the tilt is in the dead band or saturated and the new rate is zero, after the
// period division when the new rate is non-zero, and when the request lies on
// the slope only after a serial multiply and a first divider pass as well.
// in_ready rises together with out_valid, so a new tick is taken only once the
// last one is done; the divider sets the pace. A stalled receiver holds the
// output register, and the finished tick then waits in the final step with
// in_ready low.
// Reset stops the motor, selects forward, clears the rate and restores all
// settings to their defaults; no clearing pass is needed.
module tilt_to_stepper_rate_ramp_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                wr_en,
    input  logic [ttsr_pkg::IDX_W-1:0]          wr_index,
    input  logic [ttsr_pkg::TICK_W-1:0]         wr_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [ttsr_pkg::TILT_W-1:0]  tilt,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [ttsr_pkg::CFG16_W-1:0]        step_rate,
    output logic [ttsr_pkg::TICK_W-1:0]         reload_value,
    output logic [ttsr_pkg::CMP_W-1:0]          compare_value,
    output logic                                running,
    output logic                                moving_forward,
    output logic                                rate_loaded,
    output logic                                started
);

    localparam int W16 = ttsr_pkg::CFG16_W;
    localparam int PAD = ttsr_pkg::TICK_W - ttsr_pkg::REQ_ITERS;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_MUL,
        S_DIV_REQ,
        S_UPDATE,
        S_DIV_TICK,
        S_DONE
    } state_t;

    // Settings
    logic [W16-1:0]                 dead_band_reg;
    logic [W16-1:0]                 full_tilt_reg;
    logic [W16-1:0]                 min_rate_reg;
    logic [W16-1:0]                 max_rate_reg;
    logic [W16-1:0]                 ramp_step_reg;
    logic [ttsr_pkg::TICK_W-1:0]    tick_rate_reg;

    // Sequencer, tick working values and motor state
    state_t                         state_reg, state_next;
    logic [ttsr_pkg::TILT_W-1:0]    mag_reg, mag_next;
    logic                           fwd_reg, fwd_next;
    logic [W16-1:0]                 req_reg, req_next;
    logic                           is_running_reg, is_running_next;
    logic                           active_fwd_reg, active_fwd_next;
    logic [W16-1:0]                 cur_rate_reg, cur_rate_next;
    logic                           loaded_reg, loaded_next;
    logic                           started_reg, started_next;
    logic [ttsr_pkg::TICK_W-1:0]    counts_reg, counts_next;

    // Output register
    logic                           out_valid_reg, out_valid_next;
    logic [W16-1:0]                 o_rate_reg, o_rate_next;
    logic [ttsr_pkg::TICK_W-1:0]    o_reload_reg, o_reload_next;
    logic [ttsr_pkg::CMP_W-1:0]     o_compare_reg, o_compare_next;
    logic                           o_running_reg, o_running_next;
    logic                           o_fwd_reg, o_fwd_next;
    logic                           o_loaded_reg, o_loaded_next;
    logic                           o_started_reg, o_started_next;

    logic [W16-1:0]                 width_w;
    logic [W16-1:0]                 span;
    logic [ttsr_pkg::TILT_W-1:0]    d_full;
    logic                           in_band;
    logic                           saturated;
    logic                           mul_start;
    logic                           mul_done;
    logic [ttsr_pkg::PROD_W-1:0]    product;
    ttsr_pkg::div_req_t             div_req;
    logic                           div_done;
    logic [ttsr_pkg::TICK_W-1:0]    quotient;

    // Ramp update results
    logic                           upd_running;
    logic                           upd_fwd;
    logic [W16-1:0]                 upd_rate;
    logic                           upd_loaded;
    logic                           upd_started;
    logic [W16:0]                   brake_floor;
    logic [W16-1:0]                 diff;

    assign width_w   = (full_tilt_reg > dead_band_reg) ? (full_tilt_reg - dead_band_reg) : '0;
    assign span      = (max_rate_reg > min_rate_reg) ? (max_rate_reg - min_rate_reg) : '0;
    assign d_full    = mag_reg - ttsr_pkg::TILT_W'(dead_band_reg);
    assign in_band   = mag_reg <= ttsr_pkg::TILT_W'(dead_band_reg);
    assign saturated = d_full >= ttsr_pkg::TILT_W'(width_w);

    ttsr_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (d_full[W16-1:0]),
        .b       (span),
        .done    (mul_done),
        .product (product)
    );

    ttsr_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .done     (div_done),
        .quotient (quotient)
    );

    // Ramp rule applied once per tick on the registered request
    always_comb
    begin
        upd_running = is_running_reg;
        upd_fwd     = active_fwd_reg;
        upd_rate    = cur_rate_reg;
        upd_loaded  = 1'b0;
        upd_started = 1'b0;
        brake_floor = {1'b0, min_rate_reg} + {1'b0, ramp_step_reg};
        diff        = '0;
        if ((req_reg == '0 && is_running_reg) ||
            (req_reg != '0 && is_running_reg && fwd_reg != active_fwd_reg))
        begin
            // brake: step down, or stop once within one ramp step of the start rate
            if ({1'b0, cur_rate_reg} > brake_floor)
            begin
                upd_rate   = cur_rate_reg - ramp_step_reg;
                upd_loaded = 1'b1;
            end
            else
            begin
                upd_rate    = '0;
                upd_running = 1'b0;
            end
        end
        else if (req_reg != '0 && !is_running_reg)
        begin
            upd_fwd     = fwd_reg;
            upd_rate    = min_rate_reg;
            upd_running = 1'b1;
            upd_loaded  = 1'b1;
            upd_started = 1'b1;
        end
        else if (req_reg != '0 && cur_rate_reg < req_reg)
        begin
            diff       = req_reg - cur_rate_reg;
            upd_rate   = (diff <= ramp_step_reg) ? req_reg : cur_rate_reg + ramp_step_reg;
            upd_loaded = 1'b1;
        end
        else if (req_reg != '0 && cur_rate_reg > req_reg)
        begin
            diff       = cur_rate_reg - req_reg;
            upd_rate   = (diff <= ramp_step_reg) ? req_reg : cur_rate_reg - ramp_step_reg;
            upd_loaded = 1'b1;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        mag_next        = mag_reg;
        fwd_next        = fwd_reg;
        req_next        = req_reg;
        is_running_next = is_running_reg;
        active_fwd_next = active_fwd_reg;
        cur_rate_next   = cur_rate_reg;
        loaded_next     = loaded_reg;
        started_next    = started_reg;
        counts_next     = counts_reg;
        out_valid_next  = out_valid_reg;
        o_rate_next     = o_rate_reg;
        o_reload_next   = o_reload_reg;
        o_compare_next  = o_compare_reg;
        o_running_next  = o_running_reg;
        o_fwd_next      = o_fwd_reg;
        o_loaded_next   = o_loaded_reg;
        o_started_next  = o_started_reg;
        mul_start       = 1'b0;
        div_req         = '0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    mag_next   = tilt[ttsr_pkg::TILT_W-1] ? ttsr_pkg::TILT_W'(-tilt)
                                                          : ttsr_pkg::TILT_W'(tilt);
                    fwd_next   = !tilt[ttsr_pkg::TILT_W-1] && (tilt != '0);
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                if (in_band)
                begin
                    req_next   = '0;
                    state_next = S_UPDATE;
                end
                else if (saturated)
                begin
                    req_next   = min_rate_reg + span;
                    state_next = S_UPDATE;
                end
                else
                begin
                    mul_start  = 1'b1;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                if (mul_done)
                begin
                    // high half is already below the divisor, so only the low bits remain
                    div_req.start    = 1'b1;
                    div_req.rem_init = product[ttsr_pkg::PROD_W-1:W16];
                    div_req.dividend = {product[W16-1:0], {PAD{1'b0}}};
                    div_req.divisor  = width_w;
                    div_req.iters    = ttsr_pkg::ITER_W'(ttsr_pkg::REQ_ITERS);
                    state_next       = S_DIV_REQ;
                end
            end
            S_DIV_REQ:
            begin
                if (div_done)
                begin
                    req_next   = min_rate_reg + quotient[W16-1:0];
                    state_next = S_UPDATE;
                end
            end
            S_UPDATE:
            begin
                is_running_next = upd_running;
                active_fwd_next = upd_fwd;
                cur_rate_next   = upd_rate;
                loaded_next     = upd_loaded;
                started_next    = upd_started;
                if (upd_rate != '0)
                begin
                    div_req.start    = 1'b1;
                    div_req.rem_init = '0;
                    div_req.dividend = tick_rate_reg;
                    div_req.divisor  = upd_rate;
                    div_req.iters    = ttsr_pkg::ITER_W'(ttsr_pkg::TICK_ITERS);
                    state_next       = S_DIV_TICK;
                end
                else
                begin
                    counts_next = '0;
                    state_next  = S_DONE;
                end
            end
            S_DIV_TICK:
            begin
                if (div_done)
                begin
                    counts_next = quotient;
                    state_next  = S_DONE;
                end
            end
            S_DONE:
            begin
                // hold here while the previous beat is still waiting
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    o_rate_next    = cur_rate_reg;
                    o_reload_next  = (counts_reg != '0) ? counts_reg - 1'b1 : '0;
                    o_compare_next = counts_reg[ttsr_pkg::TICK_W-1:1];
                    o_running_next = is_running_reg;
                    o_fwd_next     = active_fwd_reg;
                    o_loaded_next  = loaded_reg;
                    o_started_next = started_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            mag_reg        <= '0;
            fwd_reg        <= 1'b0;
            req_reg        <= '0;
            is_running_reg <= 1'b0;
            active_fwd_reg <= 1'b1;
            cur_rate_reg   <= '0;
            loaded_reg     <= 1'b0;
            started_reg    <= 1'b0;
            counts_reg     <= '0;
            out_valid_reg  <= 1'b0;
            o_rate_reg     <= '0;
            o_reload_reg   <= '0;
            o_compare_reg  <= '0;
            o_running_reg  <= 1'b0;
            o_fwd_reg      <= 1'b1;
            o_loaded_reg   <= 1'b0;
            o_started_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            mag_reg        <= mag_next;
            fwd_reg        <= fwd_next;
            req_reg        <= req_next;
            is_running_reg <= is_running_next;
            active_fwd_reg <= active_fwd_next;
            cur_rate_reg   <= cur_rate_next;
            loaded_reg     <= loaded_next;
            started_reg    <= started_next;
            counts_reg     <= counts_next;
            out_valid_reg  <= out_valid_next;
            o_rate_reg     <= o_rate_next;
            o_reload_reg   <= o_reload_next;
            o_compare_reg  <= o_compare_next;
            o_running_reg  <= o_running_next;
            o_fwd_reg      <= o_fwd_next;
            o_loaded_reg   <= o_loaded_next;
            o_started_reg  <= o_started_next;
        end
    end

    // Settings registers; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dead_band_reg <= ttsr_pkg::RST_DEAD_BAND;
            full_tilt_reg <= ttsr_pkg::RST_FULL_TILT;
            min_rate_reg  <= ttsr_pkg::RST_MIN_RATE;
            max_rate_reg  <= ttsr_pkg::RST_MAX_RATE;
            ramp_step_reg <= ttsr_pkg::RST_RAMP_STEP;
            tick_rate_reg <= ttsr_pkg::RST_TICK_RATE;
        end
        else if (wr_en)
        begin
            case (wr_index)
                ttsr_pkg::REG_DEAD_BAND: dead_band_reg <= wr_data[W16-1:0];
                ttsr_pkg::REG_FULL_TILT: full_tilt_reg <= wr_data[W16-1:0];
                ttsr_pkg::REG_MIN_RATE:  min_rate_reg  <= wr_data[W16-1:0];
                ttsr_pkg::REG_MAX_RATE:  max_rate_reg  <= wr_data[W16-1:0];
                ttsr_pkg::REG_RAMP_STEP: ramp_step_reg <= wr_data[W16-1:0];
                ttsr_pkg::REG_TICK_RATE: tick_rate_reg <= wr_data;
                default:
                begin
                end
            endcase
        end
    end

    assign in_ready       = (state_reg == S_IDLE);
    assign out_valid      = out_valid_reg;
    assign step_rate      = o_rate_reg;
    assign reload_value   = o_reload_reg;
    assign compare_value  = o_compare_reg;
    assign running        = o_running_reg;
    assign moving_forward = o_fwd_reg;
    assign rate_loaded    = o_loaded_reg;
    assign started        = o_started_reg;

endmodule
